[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro checks on the rising edge of
// clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/bcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared types, register indexes, event codes and threshold compares.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_DOUBLE_CLICK = 3'd1,
    REG_LONG_PRESS   = 3'd2,
    REG_VERY_LONG    = 3'd3,
    REG_IDLE_LEVEL   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CLICK     = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_LONG      = 3'd3,
    EV_VERY_LONG = 3'd4
  } event_e;

  typedef struct packed {
    logic [CfgDataW-1:0] debounce_ms;
    logic [CfgDataW-1:0] double_click_ms;
    logic [CfgDataW-1:0] long_press_ms;
    logic [CfgDataW-1:0] very_long_press_ms;
    logic                idle_level;
  } cfg_t;

  typedef struct packed {
    logic             prev_level;
    logic [TimeW-1:0] press_time;
    logic [TimeW-1:0] release_time;
    logic             double_waiting;
    logic             double_on_release;
    logic             single_allowed;
    logic             skip_release;
    logic             long_done;
    logic             very_long_done;
  } state_t;

  // An elapsed time with its top bit set counts as negative and never passes.
  function automatic logic elapsed_gt(logic [TimeW-1:0] d, logic [CfgDataW-1:0] thr);
    return !d[TimeW-1] && (d[TimeW-2:0] > {{(TimeW-1-CfgDataW){1'b0}}, thr});
  endfunction

  function automatic logic elapsed_ge(logic [TimeW-1:0] d, logic [CfgDataW-1:0] thr);
    return !d[TimeW-1] && (d[TimeW-2:0] >= {{(TimeW-1-CfgDataW){1'b0}}, thr});
  endfunction

endpackage

[rtl/core/bcc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier step
// Classifies one sample against the current state and gives the next state.
// ----------------------------------------------------------------------------
module bcc_step (
  input  bcc_pkg::cfg_t        cfg_i,
  input  bcc_pkg::state_t      state_i,
  input  logic                 level_i,
  input  logic [31:0]          now_ms_i,
  output bcc_pkg::state_t      state_o,
  output bcc_pkg::event_e      event_o
);
  import bcc_pkg::*;

  logic             pressed;
  logic             was_pressed;
  logic [TimeW-1:0] since_up;
  logic [TimeW-1:0] since_down;
  logic [TimeW-1:0] since_up2;
  logic [TimeW-1:0] since_down2;
  logic             press_ev;
  logic             release_ev;
  logic             release_taken;
  state_t           st;
  event_e           ev;

  assign pressed     = level_i != cfg_i.idle_level;
  assign was_pressed = state_i.prev_level != cfg_i.idle_level;
  assign since_up    = now_ms_i - state_i.release_time;
  assign since_down  = now_ms_i - state_i.press_time;

  assign press_ev   = pressed && !was_pressed && elapsed_gt(since_up, cfg_i.debounce_ms);
  assign release_ev = !press_ev && !pressed && was_pressed &&
                      elapsed_gt(since_down, cfg_i.debounce_ms);
  assign release_taken = release_ev && !state_i.skip_release;

  // A time stamped by this sample has zero elapsed time.
  assign since_up2   = release_taken ? '0 : since_up;
  assign since_down2 = press_ev ? '0 : since_down;

  always_comb begin
    st = state_i;
    ev = EV_NONE;
    if (press_ev) begin
      st.press_time        = now_ms_i;
      st.skip_release      = 1'b0;
      st.single_allowed    = 1'b1;
      st.long_done         = 1'b0;
      st.very_long_done    = 1'b0;
      st.double_on_release = !elapsed_ge(since_up, cfg_i.double_click_ms) &&
                             !state_i.double_on_release && state_i.double_waiting;
      st.double_waiting    = 1'b0;
    end else if (release_taken) begin
      st.release_time = now_ms_i;
      if (!state_i.double_on_release) begin
        st.double_waiting = 1'b1;
      end else begin
        ev                   = EV_DOUBLE;
        st.double_on_release = 1'b0;
        st.double_waiting    = 1'b0;
        st.single_allowed    = 1'b0;
      end
    end

    if (!pressed && elapsed_ge(since_up2, cfg_i.double_click_ms) && st.double_waiting &&
        !st.double_on_release && st.single_allowed && ev != EV_DOUBLE) begin
      ev                = EV_CLICK;
      st.double_waiting = 1'b0;
    end

    if (pressed && elapsed_ge(since_down2, cfg_i.long_press_ms)) begin
      if (!st.long_done) begin
        ev                   = EV_LONG;
        st.skip_release      = 1'b1;
        st.double_on_release = 1'b0;
        st.double_waiting    = 1'b0;
        st.long_done         = 1'b1;
      end
      if (elapsed_ge(since_down2, cfg_i.very_long_press_ms) && !st.very_long_done) begin
        ev                = EV_VERY_LONG;
        st.very_long_done = 1'b1;
      end
    end

    st.prev_level = level_i;
  end

  assign state_o = st;
  assign event_o = ev;

endmodule

[rtl/core/button_click_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier
// Turns timestamped button samples into click, double-click and hold events.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one event transfer (code none when
// nothing happened). Samples are taken at one per clock cycle while the
// event register is free or being read; a sample passes through the sample
// register and then the event register. The state update classifies a
// sample and stores the new press and release times and flags in the same
// cycle as its event is registered. Configuration writes
// are always taken and should only be made while no sample is in flight.
module button_click_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        level_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  event_res_o
);
  import bcc_pkg::*;

  `include "assert_macros.svh"

  cfg_t        cfg_q;
  state_t      state_q;
  state_t      state_d;
  event_e      event_d;
  logic        s1_valid_q;
  logic        s1_level_q;
  logic [31:0] s1_now_q;
  logic        out_valid_q;
  event_e      out_event_q;
  logic        advance;
  logic        in_accept;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  bcc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .level_i  (s1_level_q),
    .now_ms_i (s1_now_q),
    .state_o  (state_d),
    .event_o  (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= 16'd20;
      cfg_q.double_click_ms    <= 16'd250;
      cfg_q.long_press_ms      <= 16'd1000;
      cfg_q.very_long_press_ms <= 16'd3000;
      cfg_q.idle_level         <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE:     cfg_q.debounce_ms        <= cfg_data_i;
        REG_DOUBLE_CLICK: cfg_q.double_click_ms    <= cfg_data_i;
        REG_LONG_PRESS:   cfg_q.long_press_ms      <= cfg_data_i;
        REG_VERY_LONG:    cfg_q.very_long_press_ms <= cfg_data_i;
        REG_IDLE_LEVEL:   cfg_q.idle_level         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_level        <= 1'b1;
      state_q.press_time        <= '1;
      state_q.release_time      <= '1;
      state_q.double_waiting    <= 1'b0;
      state_q.double_on_release <= 1'b0;
      state_q.single_allowed    <= 1'b0;
      state_q.skip_release      <= 1'b0;
      state_q.long_done         <= 1'b0;
      state_q.very_long_done    <= 1'b0;
      s1_valid_q                <= 1'b0;
      out_valid_q               <= 1'b0;
      out_event_q               <= EV_NONE;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
        out_event_q <= event_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The sample register is payload only.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_level_q <= level_i;
      s1_now_q   <= now_ms_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_event_q;

  `ASSERT_IMPLIES(a_very_long_needs_long, state_q.very_long_done, state_q.long_done,
                  "very long hold flagged without a long hold")
  `ASSERT_IMPLIES(a_skip_needs_long, state_q.skip_release, state_q.long_done,
                  "release skipped without a long hold")
  `ASSERT_IMPLIES(a_ready_when_empty, !out_valid_q, in_ready_o,
                  "sample refused while the event register is empty")
  `ASSERT_ALWAYS(a_event_code, !out_valid_q || out_event_q <= EV_VERY_LONG,
                 "event code out of range")

endmodule
